/* design/assert_macros.svh */
// Assertion helpers for the design files; the top design file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge out of reset.
`define PLT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Condition must never be seen out of reset.
`define PLT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`else

`define PLT_ASSERT(label, clk, rst_n, prop)
`define PLT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* design/plt_pkg.sv */
package plt_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int MAC_W     = 48;
    localparam int TIME_W    = 32;
    localparam int CMD_W     = 3;
    localparam int CNT_OUT_W = 5;

    localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd10000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 3'd0,
        CMD_TOUCH = 3'd1,
        CMD_QUERY = 3'd2,
        CMD_SWEEP = 3'd3,
        CMD_COUNT = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_FIN,
        S_EMIT,
        S_SW_RD,
        S_SW_CHK,
        S_SW_REM,
        S_SW_MOVE,
        S_SW_STAMP
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [MAC_W-1:0]  peer_mac;
        logic [TIME_W-1:0] now;
    } t_in_item;

    typedef struct packed {
        logic                 ok;
        logic [MAC_W-1:0]     removed_mac;
        logic [CNT_OUT_W-1:0] active_count;
        logic                 last;
    } t_out_item;

    // One read port and one write port, shared by the address and stamp memories.
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
        logic [IDX_W-1:0]  wr_idx;
        logic              addr_we;
        logic [MAC_W-1:0]  addr_wdata;
        logic              stamp_we;
        logic [TIME_W-1:0] stamp_wdata;
    } t_mem_req;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] occ;
    } t_seq_status;

    function automatic logic [CNT_OUT_W-1:0] to_count(input logic [CNT_W-1:0] v);
        logic [CNT_W+CNT_OUT_W-1:0] wide;
        wide = {{CNT_OUT_W{1'b0}}, v};
        return wide[CNT_OUT_W-1:0];
    endfunction

endpackage

/* design/plt_ram.sv */
module plt_ram #(
    parameter int DATA_W  = 32,
    parameter int ENTRIES = 16,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_idx,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_idx];
        end
    end

endmodule

/* design/plt_seq.sv */
module plt_seq
    import plt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [TIME_W-1:0] i_max_timeout,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    output t_mem_req          o_mem_req,
    input  logic [MAC_W-1:0]  i_rd_addr,
    input  logic [TIME_W-1:0] i_rd_stamp,
    output t_seq_status       o_status
);

    t_state            r_state, n_state;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [MAC_W-1:0]  r_mac, n_mac;
    logic [TIME_W-1:0] r_now, n_now;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_hit, n_hit;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_occ, n_occ;
    logic [MAC_W-1:0]  r_gone, n_gone;
    t_out_item         r_fin, n_fin;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_data, n_out_data;

    logic              out_free;
    logic              issue;
    logic              match;
    logic [TIME_W-1:0] elapsed;
    logic [CNT_W-1:0]  last_idx;
    logic              add_ok;

    assign out_free = !r_out_valid || i_out_ready;
    assign match    = (i_rd_addr == r_mac);
    assign elapsed  = r_now - i_rd_stamp;
    assign last_idx = r_occ - 1'b1;
    assign issue    = (r_idx < r_occ);
    assign add_ok   = !r_hit && (r_occ < CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_mac      <= n_mac;
        r_now      <= n_now;
        r_idx      <= n_idx;
        r_rd_idx   <= n_rd_idx;
        r_hit      <= n_hit;
        r_pos      <= n_pos;
        r_cnt      <= n_cnt;
        r_gone     <= n_gone;
        r_fin      <= n_fin;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_mac       = r_mac;
        n_now       = r_now;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_hit       = r_hit;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_occ       = r_occ;
        n_gone      = r_gone;
        n_fin       = r_fin;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        o_in_ready  = 1'b0;

        o_mem_req             = '0;
        o_mem_req.rd_idx      = r_idx[IDX_W-1:0];
        o_mem_req.wr_idx      = r_idx[IDX_W-1:0];
        o_mem_req.addr_wdata  = i_rd_addr;
        o_mem_req.stamp_wdata = i_rd_stamp;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd = i_in_data.command;
                    n_mac = i_in_data.peer_mac;
                    n_now = i_in_data.now;
                    n_idx = '0;
                    n_hit = 1'b0;
                    n_pos = '0;
                    n_cnt = '0;
                    unique case (i_in_data.command) inside
                        CMD_ADD, CMD_TOUCH, CMD_QUERY, CMD_COUNT: n_state = S_SCAN;
                        CMD_SWEEP: n_state = S_SW_RD;
                        default: begin
                            n_fin      = '0;
                            n_fin.last = 1'b1;
                            n_state    = S_EMIT;
                        end
                    endcase
                end
            end

            // Stream entries through the read port, one a cycle, and judge each
            // one in the cycle after its read.
            S_SCAN: begin
                o_mem_req.rd_en = issue;
                n_rd_vld        = issue;
                n_rd_idx        = r_idx[IDX_W-1:0];
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rd_vld) begin
                    unique case (r_cmd) inside
                        CMD_ADD: begin
                            if (match) n_hit = 1'b1;
                        end
                        CMD_TOUCH: begin
                            if (match && !r_hit) begin
                                n_hit = 1'b1;
                                n_pos = r_rd_idx;
                            end
                        end
                        CMD_QUERY: begin
                            if (match && elapsed <= i_max_timeout) n_hit = 1'b1;
                        end
                        default: begin
                            if (elapsed < i_max_timeout) n_cnt = r_cnt + 1'b1;
                        end
                    endcase
                end
                if (!issue && !r_rd_vld) begin
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                n_fin      = '0;
                n_fin.last = 1'b1;
                unique case (r_cmd) inside
                    CMD_ADD: begin
                        n_fin.ok = add_ok;
                        if (add_ok) begin
                            o_mem_req.wr_idx      = r_occ[IDX_W-1:0];
                            o_mem_req.addr_we     = 1'b1;
                            o_mem_req.addr_wdata  = r_mac;
                            o_mem_req.stamp_we    = 1'b1;
                            o_mem_req.stamp_wdata = r_now;
                            n_occ                 = r_occ + 1'b1;
                        end
                    end
                    CMD_TOUCH: begin
                        n_fin.ok = r_hit;
                        if (r_hit) begin
                            o_mem_req.wr_idx      = r_pos;
                            o_mem_req.stamp_we    = 1'b1;
                            o_mem_req.stamp_wdata = r_now;
                        end
                    end
                    CMD_QUERY: n_fin.ok = r_hit;
                    default:   n_fin.active_count = to_count(r_cnt);
                endcase
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_fin;
                    n_state     = S_IDLE;
                end
            end

            S_SW_RD: begin
                if (issue) begin
                    o_mem_req.rd_en = 1'b1;
                    n_state         = S_SW_CHK;
                end else begin
                    n_idx   = '0;
                    n_state = S_SW_STAMP;
                end
            end

            S_SW_CHK: begin
                if (elapsed > i_max_timeout) begin
                    n_gone  = i_rd_addr;
                    n_state = S_SW_REM;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SW_RD;
                end
            end

            // Emit the removal, then pull the last occupied entry into the gap unless it was the last.
            S_SW_REM: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out_data              = '0;
                    n_out_data.ok           = 1'b1;
                    n_out_data.removed_mac  = r_gone;
                    if (r_idx == last_idx) begin
                        n_occ   = last_idx;
                        n_state = S_SW_RD;
                    end else begin
                        o_mem_req.rd_en  = 1'b1;
                        o_mem_req.rd_idx = last_idx[IDX_W-1:0];
                        n_state          = S_SW_MOVE;
                    end
                end
            end

            // Same index is examined again on the next read.
            S_SW_MOVE: begin
                o_mem_req.addr_we  = 1'b1;
                o_mem_req.stamp_we = 1'b1;
                n_occ              = last_idx;
                n_state            = S_SW_RD;
            end

            S_SW_STAMP: begin
                if (issue) begin
                    o_mem_req.stamp_we    = 1'b1;
                    o_mem_req.stamp_wdata = r_now;
                    n_idx                 = r_idx + 1'b1;
                end else begin
                    n_fin              = '0;
                    n_fin.ok           = 1'b1;
                    n_fin.active_count = to_count(r_occ);
                    n_fin.last         = 1'b1;
                    n_state            = S_EMIT;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_data    = r_out_data;
    assign o_status.busy = (r_state != S_IDLE);
    assign o_status.occ  = r_occ;

endmodule

/* design/peer_liveness_timeout_table.sv */
// Channel   Signals                                   Transfer when
// input     i_in_valid / o_in_ready / i_in_data       i_in_valid & o_in_ready
// output    o_out_valid / i_out_ready / o_out_data    o_out_valid & i_out_ready
// config    i_cfg_wr_en / i_cfg_wr_data               i_cfg_wr_en
//
// Add, touch, query and count stream the occupied entries through the
// registered read port of the table memories; the result is settled in the
// finish state, loaded into the output register from the emit state, and the
// next input is taken back in idle. Sweep emits each expired entry, fills its
// slot with the last occupied entry, restamps the rest and emits the count.
// A result waiting in the output register holds the next emission; the next
// item may be taken meanwhile. Reset empties the table at once.
`include "assert_macros.svh"

module peer_liveness_timeout_table
    import plt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TIME_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data
);

    logic [TIME_W-1:0] r_max_timeout;
    t_mem_req          mem_req;
    t_seq_status       st;
    logic [MAC_W-1:0]  rd_addr;
    logic [TIME_W-1:0] rd_stamp;
    logic              mem_we;
    logic [CNT_W-1:0]  r_occ_prev;
    logic              occ_step_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_timeout <= TIMEOUT_RST;
        end else if (i_cfg_wr_en) begin
            r_max_timeout <= i_cfg_wr_data;
        end
    end

    plt_ram #(
        .DATA_W  (MAC_W),
        .ENTRIES (DEPTH)
    ) u_addr_ram (
        .i_clk     (i_clk),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_idx  (mem_req.rd_idx),
        .o_rd_data (rd_addr),
        .i_wr_en   (mem_req.addr_we),
        .i_wr_idx  (mem_req.wr_idx),
        .i_wr_data (mem_req.addr_wdata)
    );

    plt_ram #(
        .DATA_W  (TIME_W),
        .ENTRIES (DEPTH)
    ) u_stamp_ram (
        .i_clk     (i_clk),
        .i_rd_en   (mem_req.rd_en),
        .i_rd_idx  (mem_req.rd_idx),
        .o_rd_data (rd_stamp),
        .i_wr_en   (mem_req.stamp_we),
        .i_wr_idx  (mem_req.wr_idx),
        .i_wr_data (mem_req.stamp_wdata)
    );

    plt_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_timeout (r_max_timeout),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data),
        .o_mem_req     (mem_req),
        .i_rd_addr     (rd_addr),
        .i_rd_stamp    (rd_stamp),
        .o_status      (st)
    );

    assign mem_we = mem_req.addr_we || mem_req.stamp_we;

    always_ff @(posedge i_clk) begin
        r_occ_prev <= st.occ;
    end

    // occupancy moves by at most one entry a cycle
    assign occ_step_ok = (st.occ == r_occ_prev) || (st.occ == r_occ_prev + 1'b1)
                      || (st.occ + 1'b1 == r_occ_prev);

    `PLT_NEVER(a_occ_bound, i_clk, i_rst_n, st.occ > CNT_W'(DEPTH))
    `PLT_ASSERT(a_busy_after_take, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> st.busy)
    `PLT_ASSERT(a_occ_step, i_clk, i_rst_n, $past(i_rst_n) |-> occ_step_ok)
    `PLT_NEVER(a_wr_range, i_clk, i_rst_n, mem_we && (CNT_W'(mem_req.wr_idx) >= CNT_W'(DEPTH)))

endmodule

/* bench/liveness_checker.sv */
`timescale 1ns / 100ps

module liveness_checker
    import plt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [TIME_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  t_in_item          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  t_out_item         i_out_data,
    output int                o_fail_count,
    output int                o_pending
);

    logic [MAC_W-1:0]  peer_addr [DEPTH];
    logic [TIME_W-1:0] peer_seen [DEPTH];
    int unsigned       peer_count;
    logic [TIME_W-1:0] timeout_ticks;
    t_out_item         expected_q[$];
    t_out_item         want;
    int                mismatches = 0;
    int                waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function automatic t_out_item make_result(input logic ok, input logic [MAC_W-1:0] mac,
                                              input int unsigned cnt, input logic last);
        t_out_item res;
        res.ok           = ok;
        res.removed_mac  = mac;
        res.active_count = CNT_OUT_W'(cnt);
        res.last         = last;
        return res;
    endfunction

    function automatic int find_peer(input logic [MAC_W-1:0] mac);
        for (int i = 0; i < peer_count; i++) begin
            if (peer_addr[i] == mac) return i;
        end
        return -1;
    endfunction

    // Work out every result one command causes and update the shadow table.
    task automatic predict_results(input t_in_item it);
        int                pos;
        int unsigned       idx;
        int unsigned       tail;
        int unsigned       hits;
        logic [TIME_W-1:0] age;
        logic [MAC_W-1:0]  gone;
        logic              active;
        case (it.command)
            CMD_ADD: begin
                if (find_peer(it.peer_mac) < 0 && peer_count < DEPTH) begin
                    peer_addr[peer_count] = it.peer_mac;
                    peer_seen[peer_count] = it.now;
                    peer_count++;
                    expected_q.push_back(make_result(1'b1, '0, 0, 1'b1));
                end else begin
                    expected_q.push_back(make_result(1'b0, '0, 0, 1'b1));
                end
            end
            CMD_TOUCH: begin
                pos = find_peer(it.peer_mac);
                if (pos >= 0) peer_seen[pos] = it.now;
                expected_q.push_back(make_result(pos >= 0, '0, 0, 1'b1));
            end
            CMD_QUERY: begin
                active = 1'b0;
                for (int i = 0; i < peer_count; i++) begin
                    age = it.now - peer_seen[i];
                    if (peer_addr[i] == it.peer_mac && age <= timeout_ticks) active = 1'b1;
                end
                expected_q.push_back(make_result(active, '0, 0, 1'b1));
            end
            CMD_SWEEP: begin
                idx = 0;
                while (idx < peer_count) begin
                    age = it.now - peer_seen[idx];
                    if (age > timeout_ticks) begin
                        // swap in the last occupied entry and look at this slot again
                        tail = peer_count - 1;
                        gone = peer_addr[idx];
                        expected_q.push_back(make_result(1'b1, gone, 0, 1'b0));
                        peer_addr[idx]  = peer_addr[tail];
                        peer_seen[idx]  = peer_seen[tail];
                        peer_addr[tail] = gone;
                        peer_count      = tail;
                    end else begin
                        idx++;
                    end
                end
                for (int i = 0; i < peer_count; i++) peer_seen[i] = it.now;
                expected_q.push_back(make_result(1'b1, '0, peer_count, 1'b1));
            end
            CMD_COUNT: begin
                hits = 0;
                for (int i = 0; i < peer_count; i++) begin
                    age = it.now - peer_seen[i];
                    if (age < timeout_ticks) hits++;
                end
                expected_q.push_back(make_result(1'b0, '0, hits, 1'b1));
            end
            default: begin
                expected_q.push_back(make_result(1'b0, '0, 0, 1'b1));
            end
        endcase
    endtask

    task automatic check_field(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            peer_count    = 0;
            timeout_ticks = TIMEOUT_RST;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) timeout_ticks = i_cfg_wr_data;
            if (i_in_valid && i_in_ready) predict_results(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transfer with nothing expected, actual %0h",
                             $time, i_out_data);
                end else begin
                    want = expected_q.pop_front();
                    check_field("ok", 64'(want.ok), 64'(i_out_data.ok));
                    check_field("removed_mac", 64'(want.removed_mac),
                                64'(i_out_data.removed_mac));
                    check_field("active_count", 64'(want.active_count),
                                64'(i_out_data.active_count));
                    check_field("last", 64'(want.last), 64'(i_out_data.last));
                end
            end
        end
        waiting = expected_q.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import plt_pkg::*;

    localparam int RUN_LIMIT       = 3_000_000;
    localparam int POOL_SIZE       = 20;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int NUM_PHASES      = 5;
    localparam int HOLD_OFF_CYCLES = 400;

    // command codes the block does not define
    localparam logic [CMD_W-1:0]  CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_SPARE_HI = 3'd7;
    localparam logic [MAC_W-1:0]  MAC_ALL_ONES = '1;
    localparam logic [MAC_W-1:0]  MAC_ZERO     = '0;
    localparam logic [TIME_W-1:0] T_BASE       = 32'hFFFF_FFF0;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [TIME_W-1:0] cfg_wr_data = '0;
    logic              in_valid    = 1'b0;
    t_in_item          in_data     = '0;
    logic              out_ready   = 1'b0;
    logic              in_ready;
    logic              out_valid;
    t_out_item         out_data;
    int                fail_count;
    int                pending;
    int                cycles      = 0;
    bit                hold_off_req = 1'b0;

    logic [MAC_W-1:0]  mac_pool [POOL_SIZE];
    logic [TIME_W-1:0] now_t;
    logic [TIME_W-1:0] sweep_t;
    logic [TIME_W-1:0] timeout_now;
    logic [TIME_W-1:0] phase_timeouts [NUM_PHASES];

    always #10 clk = ~clk;

    peer_liveness_timeout_table dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_data    (out_data)
    );

    liveness_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("** peer_liveness_timeout_table: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one command and hold it until the transfer.
    task automatic send(input logic [CMD_W-1:0] cmd, input logic [MAC_W-1:0] mac,
                        input logic [TIME_W-1:0] stamp, input int gap);
        if (gap > 0) begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= '{command: cmd, peer_mac: mac, now: stamp};
        do @(posedge clk); while (!in_ready);
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic drain();
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_timeout(input logic [TIME_W-1:0] ticks);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        timeout_now = ticks;
        @(negedge clk) cfg_wr_en <= 1'b0;
    endtask

    task automatic random_command(input int gap);
        int                r;
        int                k;
        logic [TIME_W-1:0] span;
        logic [MAC_W-1:0]  mac;
        logic [CMD_W-1:0]  cmd;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 9);
        span = timeout_now >> 3;
        if (span < 4) span = 4;
        if (k < 5) now_t = now_t + $urandom_range(0, span);
        else if (k < 7) now_t = now_t + $urandom_range(0, 3);
        // land within one tick of the timeout boundary since the last sweep restamp
        else if (k < 9) now_t = sweep_t + timeout_now - 1 + $urandom_range(0, 2);
        else now_t = $urandom();
        if ($urandom_range(0, 19) == 0) mac = {16'($urandom_range(0, 16'hFFFF)), $urandom()};
        else mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 30) cmd = CMD_ADD;
        else if (r < 45) cmd = CMD_TOUCH;
        else if (r < 65) cmd = CMD_QUERY;
        else if (r < 78) cmd = CMD_COUNT;
        else if (r < 96) cmd = CMD_SWEEP;
        else cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        if (cmd == CMD_SWEEP) sweep_t = now_t;
        send(cmd, mac, now_t, gap);
    endtask

    // Receiver: stretches of steady, patchy and stalled acceptance.
    initial begin
        int seg;
        int mode;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                @(negedge clk) out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            seg  = $urandom_range(1, 40);
            mode = $urandom_range(0, 9);
            repeat (seg) begin
                @(negedge clk);
                if (mode < 4) out_ready <= 1'b1;
                else if (mode < 7) out_ready <= ($urandom_range(0, 3) != 0);
                else if (mode < 9) out_ready <= $urandom_range(0, 1);
                else out_ready <= 1'b0;
            end
        end
    end

    initial begin
        bit steady;
        mac_pool[0] = MAC_ZERO;
        mac_pool[1] = MAC_ALL_ONES;
        for (int i = 2; i < POOL_SIZE; i++) mac_pool[i] = {16'($urandom_range(0, 16'hFFFF)), $urandom()};
        timeout_now = TIMEOUT_RST;
        phase_timeouts[0] = 32'hFFFF_FFFF;
        phase_timeouts[1] = 32'd0;
        phase_timeouts[2] = $urandom_range(1, 64);
        phase_timeouts[3] = $urandom();
        phase_timeouts[4] = $urandom_range(500, 20000);

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // empty table
        send(CMD_QUERY, MAC_ZERO, 32'd0, pick_gap());
        send(CMD_COUNT, MAC_ZERO, 32'd0, pick_gap());
        send(CMD_SWEEP, MAC_ZERO, 32'd0, pick_gap());
        // add, duplicate add, unknown and wrapped touch
        send(CMD_ADD, MAC_ALL_ONES, T_BASE, pick_gap());
        send(CMD_ADD, MAC_ALL_ONES, T_BASE + 3, pick_gap());
        send(CMD_ADD, MAC_ZERO, 32'd5, pick_gap());
        send(CMD_TOUCH, mac_pool[2], 32'd6, pick_gap());
        send(CMD_TOUCH, MAC_ZERO, 32'hFFFF_FFFF, pick_gap());
        // elapsed exactly at the timeout: active for query, not for count
        send(CMD_QUERY, MAC_ALL_ONES, T_BASE + TIMEOUT_RST, pick_gap());
        send(CMD_COUNT, MAC_ZERO, T_BASE + TIMEOUT_RST, pick_gap());
        send(CMD_QUERY, MAC_ALL_ONES, T_BASE + TIMEOUT_RST + 1, pick_gap());
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            send(CMD_W'(c), MAC_ALL_ONES, $urandom(), pick_gap());
        // fill the table, then overflow it
        for (int i = 2; i < DEPTH; i++)
            send(CMD_ADD, mac_pool[i], T_BASE + i * 1000, pick_gap());
        send(CMD_ADD, mac_pool[DEPTH], T_BASE + 16000, pick_gap());
        // several removals with compaction, then count after the restamp
        send(CMD_SWEEP, MAC_ZERO, T_BASE + 16000, pick_gap());
        send(CMD_COUNT, MAC_ZERO, T_BASE + 16000, pick_gap());
        drain();

        now_t   = T_BASE + 16000;
        sweep_t = now_t;
        hold_off_req = 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_timeout(phase_timeouts[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 30 == 0) steady = ($urandom_range(0, 3) == 0);
                random_command(steady ? 0 : pick_gap());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("** peer_liveness_timeout_table: PASSED **");
        end else begin
            $display("** peer_liveness_timeout_table: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/plt_pkg.sv
design/plt_ram.sv
design/plt_seq.sv
design/peer_liveness_timeout_table.sv
bench/liveness_checker.sv
bench/tb_top.sv
